FILE: hw/rtl/salc_pkg.sv
// Shared constants and handshake types for the set-associative LRU cache tag model.
// No dependencies; imported by salc_div and set_assoc_lru_cache_tag_model.
package salc_pkg;

    localparam int MAX_SETS   = 256;
    localparam int MAX_WAYS   = 8;
    localparam int ADDR_BITS  = 32;
    localparam int COUNT_BITS = 32;

    localparam int SET_BITS   = $clog2(MAX_SETS);
    localparam int WAY_BITS   = $clog2(MAX_WAYS);
    localparam int AGE_BITS   = WAY_BITS;
    localparam int LINE_BITS  = SET_BITS + WAY_BITS;
    localparam int DSR_BITS   = 13;
    localparam int SETS_W     = 9;
    localparam int WAYS_W     = 4;
    localparam int STEP_BITS  = $clog2(ADDR_BITS);

    // configuration register indexes
    localparam logic [1:0] CFG_BLOCK_BYTES = 2'd0;
    localparam logic [1:0] CFG_SETS_IN_USE = 2'd1;
    localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

    typedef struct packed {
        logic                 start;
        logic [ADDR_BITS-1:0] dividend;
        logic [DSR_BITS-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [ADDR_BITS-1:0] quotient;
        logic [DSR_BITS-1:0]  remainder;
    } div_rsp_t;

endpackage

FILE: hw/rtl/salc_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on salc_pkg for widths and the request/response structs.
module salc_div
    import salc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] cnt_reg;
    logic [ADDR_BITS-1:0] dvd_reg;
    logic [DSR_BITS-1:0]  dsr_reg;
    logic [DSR_BITS-1:0]  rem_reg;

    logic [DSR_BITS:0]    trial;
    logic                 qbit;
    logic [DSR_BITS:0]    diff;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[ADDR_BITS-1]};
        qbit  = (trial >= {1'b0, dsr_reg});
        diff  = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= qbit ? diff[DSR_BITS-1:0] : trial[DSR_BITS-1:0];
                dvd_reg <= {dvd_reg[ADDR_BITS-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_BITS'(ADDR_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: hw/rtl/set_assoc_lru_cache_tag_model.sv
// Top level: set-associative cache tag model with LRU replacement and hit/miss statistics.
// Depends on salc_pkg and salc_div (shared serial divider).
//
//  channel   handshake                   payload
//  access    start / busy                req_type, access_address
//  config    cfg_valid / cfg_ready       cfg_index, cfg_data
//  result    done (one-cycle strobe)     miss, set_index, total_accesses, counters, set_misses
//
// An item takes two 32-step passes of the serial divider (address by
// block size, then quotient by sets), a read state and a check state per way for the tag and
// age memories, a write-back state per way, and a final count update.
// After reset every set reads as empty (tags 0, way j at age j) by a per-set valid bit;
// no clearing pass. The result strobe cannot be stalled; cfg_ready is high while idle.
module set_assoc_lru_cache_tag_model
    import salc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  req_type,
    input  logic [ADDR_BITS-1:0]  access_address,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [DSR_BITS-1:0]   cfg_data,
    output logic                  done,
    output logic                  miss,
    output logic [SET_BITS-1:0]   set_index,
    output logic [COUNT_BITS-1:0] total_accesses,
    output logic [COUNT_BITS-1:0] read_hits,
    output logic [COUNT_BITS-1:0] read_misses,
    output logic [COUNT_BITS-1:0] write_hits,
    output logic [COUNT_BITS-1:0] write_misses,
    output logic [COUNT_BITS-1:0] set_misses
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1,
        S_DIV2,
        S_RD,
        S_CHK,
        S_UPD,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [DSR_BITS-1:0]   block_bytes_reg;
    logic [SETS_W-1:0]     sets_in_use_reg;
    logic [WAYS_W-1:0]     ways_in_use_reg;

    logic                  is_write_reg;
    logic [ADDR_BITS-1:0]  tag_reg;
    logic [SET_BITS-1:0]   set_reg;
    logic [WAY_BITS-1:0]   way_reg;
    logic                  hit_reg;
    logic [AGE_BITS-1:0]   ref_reg;
    logic [MAX_SETS-1:0]   set_valid_reg;
    logic [ADDR_BITS-1:0]  wtag_reg [MAX_WAYS];
    logic [AGE_BITS-1:0]   wage_reg [MAX_WAYS];

    logic [COUNT_BITS-1:0] acc_cnt_reg;
    logic [COUNT_BITS-1:0] rh_cnt_reg;
    logic [COUNT_BITS-1:0] rm_cnt_reg;
    logic [COUNT_BITS-1:0] wh_cnt_reg;
    logic [COUNT_BITS-1:0] wm_cnt_reg;

    logic                  done_reg;
    logic                  miss_reg;
    logic [SET_BITS-1:0]   set_out_reg;
    logic [COUNT_BITS-1:0] acc_out_reg;
    logic [COUNT_BITS-1:0] rh_out_reg;
    logic [COUNT_BITS-1:0] rm_out_reg;
    logic [COUNT_BITS-1:0] wh_out_reg;
    logic [COUNT_BITS-1:0] wm_out_reg;
    logic [COUNT_BITS-1:0] sm_out_reg;

    // memories
    logic [ADDR_BITS-1:0]  tag_mem [MAX_SETS*MAX_WAYS];
    logic [AGE_BITS-1:0]   age_mem [MAX_SETS*MAX_WAYS];
    logic [COUNT_BITS-1:0] sm_mem  [MAX_SETS];
    logic [ADDR_BITS-1:0]  tag_rd_reg;
    logic [AGE_BITS-1:0]   age_rd_reg;
    logic [COUNT_BITS-1:0] sm_rd_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [DSR_BITS-1:0]   eff_blocks;
    logic [SETS_W-1:0]     eff_sets;
    logic [WAYS_W-1:0]     eff_ways;
    logic                  accept;
    logic [LINE_BITS-1:0]  line_addr;
    logic                  set_ok;
    logic [ADDR_BITS-1:0]  rd_tag;
    logic [AGE_BITS-1:0]   rd_age;
    logic                  way_used;
    logic [ADDR_BITS-1:0]  wr_tag;
    logic [AGE_BITS-1:0]   wr_age;
    logic                  mem_we;
    logic [COUNT_BITS-1:0] sm_old;
    logic [COUNT_BITS-1:0] sm_new;

    salc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        eff_blocks = (block_bytes_reg == '0) ? DSR_BITS'(1) : block_bytes_reg;
        if (sets_in_use_reg == '0)
            eff_sets = SETS_W'(1);
        else if (sets_in_use_reg > SETS_W'(MAX_SETS))
            eff_sets = SETS_W'(MAX_SETS);
        else
            eff_sets = sets_in_use_reg;
        if (ways_in_use_reg == '0)
            eff_ways = WAYS_W'(1);
        else if (ways_in_use_reg > WAYS_W'(MAX_WAYS))
            eff_ways = WAYS_W'(MAX_WAYS);
        else
            eff_ways = ways_in_use_reg;
    end

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    // geometry must not change while an item is in flight
    assign cfg_ready = !busy;

    always_comb
    begin
        div_req.start    = accept || (state_reg == S_DIV1 && div_rsp.done);
        div_req.dividend = (state_reg == S_IDLE) ? access_address : div_rsp.quotient;
        div_req.divisor  = (state_reg == S_IDLE) ? eff_blocks
                                                 : DSR_BITS'(eff_sets);
    end

    assign line_addr = {set_reg, way_reg};
    assign set_ok    = set_valid_reg[set_reg];
    // untouched sets read as reset contents
    assign rd_tag    = set_ok ? tag_rd_reg : '0;
    assign rd_age    = set_ok ? age_rd_reg : AGE_BITS'(way_reg);
    assign way_used  = ({1'b0, way_reg} < eff_ways);

    always_comb
    begin
        wr_tag = wtag_reg[way_reg];
        wr_age = wage_reg[way_reg];
        if (way_used)
        begin
            if (wage_reg[way_reg] < ref_reg)
                wr_age = wage_reg[way_reg] + 1'b1;
            else if (wage_reg[way_reg] == ref_reg)
            begin
                wr_tag = tag_reg;
                wr_age = '0;
            end
        end
    end

    assign mem_we = (state_reg == S_UPD);
    assign sm_old = set_ok ? sm_rd_reg : '0;
    assign sm_new = sm_old + COUNT_BITS'(!hit_reg);

    always_ff @(posedge clk)
    begin
        tag_rd_reg <= tag_mem[line_addr];
        age_rd_reg <= age_mem[line_addr];
        sm_rd_reg  <= sm_mem[set_reg];
        if (mem_we)
        begin
            tag_mem[line_addr] <= wr_tag;
            age_mem[line_addr] <= wr_age;
        end
        if (state_reg == S_DONE)
            sm_mem[set_reg] <= sm_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            block_bytes_reg <= DSR_BITS'(64);
            sets_in_use_reg <= SETS_W'(256);
            ways_in_use_reg <= WAYS_W'(8);
            is_write_reg    <= 1'b0;
            tag_reg         <= '0;
            set_reg         <= '0;
            way_reg         <= '0;
            hit_reg         <= 1'b0;
            ref_reg         <= '0;
            set_valid_reg   <= '0;
            for (int i = 0; i < MAX_WAYS; i++)
            begin
                wtag_reg[i] <= '0;
                wage_reg[i] <= '0;
            end
            acc_cnt_reg     <= '0;
            rh_cnt_reg      <= '0;
            rm_cnt_reg      <= '0;
            wh_cnt_reg      <= '0;
            wm_cnt_reg      <= '0;
            done_reg        <= 1'b0;
            miss_reg        <= 1'b0;
            set_out_reg     <= '0;
            acc_out_reg     <= '0;
            rh_out_reg      <= '0;
            rm_out_reg      <= '0;
            wh_out_reg      <= '0;
            wm_out_reg      <= '0;
            sm_out_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_BLOCK_BYTES: block_bytes_reg <= cfg_data;
                    CFG_SETS_IN_USE: sets_in_use_reg <= cfg_data[SETS_W-1:0];
                    CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[WAYS_W-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        is_write_reg <= req_type;
                        acc_cnt_reg  <= acc_cnt_reg + 1'b1;
                        state_reg    <= S_DIV1;
                    end
                end
                S_DIV1:
                begin
                    if (div_rsp.done)
                        state_reg <= S_DIV2;
                end
                S_DIV2:
                begin
                    if (div_rsp.done)
                    begin
                        set_reg   <= div_rsp.remainder[SET_BITS-1:0];
                        tag_reg   <= div_rsp.quotient;
                        way_reg   <= '0;
                        hit_reg   <= 1'b0;
                        ref_reg   <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    wtag_reg[way_reg] <= rd_tag;
                    wage_reg[way_reg] <= rd_age;
                    // first match wins and its age becomes the reference; on a miss, the oldest age among used ways
                    if (way_used && !hit_reg)
                    begin
                        if (rd_tag == tag_reg)
                        begin
                            hit_reg <= 1'b1;
                            ref_reg <= rd_age;
                        end
                        else if (rd_age > ref_reg)
                            ref_reg <= rd_age;
                    end
                    if (way_reg == WAY_BITS'(MAX_WAYS - 1))
                    begin
                        way_reg   <= '0;
                        state_reg <= S_UPD;
                    end
                    else
                    begin
                        way_reg   <= way_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_UPD:
                begin
                    // all ways are written back so the set holds real contents once valid
                    if (way_reg == WAY_BITS'(MAX_WAYS - 1))
                        state_reg <= S_DONE;
                    else
                        way_reg <= way_reg + 1'b1;
                end
                S_DONE:
                begin
                    set_valid_reg[set_reg] <= 1'b1;
                    done_reg    <= 1'b1;
                    miss_reg    <= !hit_reg;
                    set_out_reg <= set_reg;
                    acc_out_reg <= acc_cnt_reg;
                    sm_out_reg  <= sm_new;
                    rh_out_reg  <= rh_cnt_reg;
                    rm_out_reg  <= rm_cnt_reg;
                    wh_out_reg  <= wh_cnt_reg;
                    wm_out_reg  <= wm_cnt_reg;
                    priority if (is_write_reg && hit_reg)
                    begin
                        wh_cnt_reg <= wh_cnt_reg + 1'b1;
                        wh_out_reg <= wh_cnt_reg + 1'b1;
                    end
                    else if (is_write_reg)
                    begin
                        wm_cnt_reg <= wm_cnt_reg + 1'b1;
                        wm_out_reg <= wm_cnt_reg + 1'b1;
                    end
                    else if (hit_reg)
                    begin
                        rh_cnt_reg <= rh_cnt_reg + 1'b1;
                        rh_out_reg <= rh_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        rm_cnt_reg <= rm_cnt_reg + 1'b1;
                        rm_out_reg <= rm_cnt_reg + 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done           = done_reg;
    assign miss           = miss_reg;
    assign set_index      = set_out_reg;
    assign total_accesses = acc_out_reg;
    assign read_hits      = rh_out_reg;
    assign read_misses    = rm_out_reg;
    assign write_hits     = wh_out_reg;
    assign write_misses   = wm_out_reg;
    assign set_misses     = sm_out_reg;

endmodule
